[src/gld_pkg.sv]
// Package for the greedy label decoder: field widths, codes and the
// configuration record. No dependencies.
package gld_pkg;

  localparam int SCORE_W    = 32;
  localparam int TIME_W     = 16;
  localparam int TOTAL_W    = 48;
  localparam int TRANS_W    = 3;
  localparam int ACT_W      = 2;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [TRANS_W-1:0] {
    TR_LABEL_LABEL = 3'd0,
    TR_LABEL_LOOP  = 3'd1,
    TR_LABEL_BLANK = 3'd2,
    TR_BLANK_LABEL = 3'd3,
    TR_BLANK_LOOP  = 3'd4
  } trans_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_PUSH   = 2'd1,
    ACT_UPDATE = 2'd2
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLANK_LABEL   = 2'd0,
    CFG_ALLOW_LOOP    = 2'd1,
    CFG_USE_SENT_END  = 2'd2,
    CFG_SENT_END_LBL  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] blank_label;
    logic                  allow_label_loop;
    logic                  use_sentence_end;
    logic [CFG_DATA_W-1:0] sentence_end_label;
  } cfg_t;

endpackage

[src/gld_if.sv]
// Handshake channels of the greedy label decoder: candidate input and
// result output. Depends on gld_pkg.
interface gld_in_if import gld_pkg::*; #(
  parameter int LABEL_BITS = 12
);
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [LABEL_BITS-1:0]     label;
  logic signed [SCORE_W-1:0] score;
  logic [TIME_W-1:0]         timestep;
  logic                      last_label;

  modport source (output valid, mode, label, score, timestep, last_label, input ready);
  modport sink   (input valid, mode, label, score, timestep, last_label, output ready);
endinterface

interface gld_out_if import gld_pkg::*; #(
  parameter int LABEL_BITS = 12
);
  logic                      valid;
  logic                      ready;
  logic [LABEL_BITS-1:0]     best_label;
  logic [TRANS_W-1:0]        transition;
  logic signed [TOTAL_W-1:0] total_score;
  logic [ACT_W-1:0]          trace_action;
  logic [TIME_W-1:0]         trace_time;
  logic                      stop;

  modport source (output valid, best_label, transition, total_score, trace_action,
                  trace_time, stop, input ready);
  modport sink   (input valid, best_label, transition, total_score, trace_action,
                  trace_time, stop, output ready);
endinterface

[src/gld_cfg.sv]
// Configuration register file of the greedy label decoder.
// Depends on gld_pkg.
module gld_cfg import gld_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BLANK_LABEL:  cfg_d.blank_label        = cfg_data_i;
        CFG_ALLOW_LOOP:   cfg_d.allow_label_loop   = cfg_data_i[0];
        CFG_USE_SENT_END: cfg_d.use_sentence_end   = cfg_data_i[0];
        CFG_SENT_END_LBL: cfg_d.sentence_end_label = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/gld_in_reg.sv]
// Input register of the greedy label decoder: holds one candidate beat
// until the step stage takes it. Depends on gld_pkg and gld_in_if.
module gld_in_reg import gld_pkg::*; #(
  parameter int LABEL_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gld_in_if.sink                    in_ch,
  input  logic                      take_i,
  output logic                      vld_o,
  output logic                      mode_o,
  output logic [LABEL_BITS-1:0]     label_o,
  output logic signed [SCORE_W-1:0] score_o,
  output logic [TIME_W-1:0]         timestep_o,
  output logic                      last_o
);

  logic                      vld_q, vld_d;
  logic                      mode_q;
  logic [LABEL_BITS-1:0]     label_q;
  logic signed [SCORE_W-1:0] score_q;
  logic [TIME_W-1:0]         time_q;
  logic                      last_q;
  logic                      load;

  assign in_ch.ready = !vld_q || take_i;
  assign load        = in_ch.valid && in_ch.ready;
  assign vld_d       = load ? 1'b1 : (take_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q  <= in_ch.mode;
      label_q <= in_ch.label;
      score_q <= in_ch.score;
      time_q  <= in_ch.timestep;
      last_q  <= in_ch.last_label;
    end
  end

  assign vld_o      = vld_q;
  assign mode_o     = mode_q;
  assign label_o    = label_q;
  assign score_o    = score_q;
  assign timestep_o = time_q;
  assign last_o     = last_q;

endmodule

[src/gld_step.sv]
// Step stage of the greedy label decoder: running minimum, transition,
// saturating total and traceback action, into the result register.
// Depends on gld_pkg and gld_out_if.
module gld_step import gld_pkg::*; #(
  parameter int LABEL_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      vld_i,
  input  logic                      mode_i,
  input  logic [LABEL_BITS-1:0]     label_i,
  input  logic signed [SCORE_W-1:0] score_i,
  input  logic [TIME_W-1:0]         timestep_i,
  input  logic                      last_i,
  output logic                      take_o,
  gld_out_if.source                 out_ch
);

  // hypothesis state
  logic [LABEL_BITS-1:0]     prev_label_q, prev_label_d;
  logic                      prev_vld_q, prev_vld_d;
  logic signed [SCORE_W-1:0] best_score_q, best_score_d;
  logic [LABEL_BITS-1:0]     best_label_q, best_label_d;
  logic [TIME_W-1:0]         best_time_q, best_time_d;
  logic                      have_q, have_d;
  logic signed [TOTAL_W-1:0] acc_q, acc_d;
  logic                      trace_ne_q, trace_ne_d;

  // result register
  logic                      res_vld_q, res_vld_d;
  logic [LABEL_BITS-1:0]     res_label_q;
  trans_e                    res_trans_q;
  logic signed [TOTAL_W-1:0] res_total_q;
  act_e                      res_act_q;
  logic [TIME_W-1:0]         res_time_q;
  logic                      res_stop_q;

  logic                      upd;
  logic signed [SCORE_W-1:0] nb_score;
  logic [LABEL_BITS-1:0]     nb_label;
  logic [TIME_W-1:0]         nb_time;
  logic [LABEL_BITS-1:0]     blank;
  logic                      prev_blank, next_blank, is_loop;
  trans_e                    trans;
  act_e                      act;
  logic signed [TOTAL_W:0]   sum;
  logic signed [TOTAL_W-1:0] total;
  logic                      stop;
  logic                      emit;

  localparam logic signed [TOTAL_W-1:0] TotMax = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TotMin = {1'b1, {(TOTAL_W-1){1'b0}}};

  assign take_o = vld_i && (!res_vld_q || out_ch.ready);
  assign emit   = take_o && !mode_i && last_i;

  always_comb begin
    upd      = !have_q || (score_i < best_score_q);
    nb_score = upd ? score_i    : best_score_q;
    nb_label = upd ? label_i    : best_label_q;
    nb_time  = upd ? timestep_i : best_time_q;

    blank      = LABEL_BITS'(cfg_i.blank_label);
    prev_blank = prev_vld_q && (prev_label_q == blank);
    next_blank = (nb_label == blank);
    if (prev_blank) begin
      trans = next_blank ? TR_BLANK_LOOP : TR_BLANK_LABEL;
    end else if (next_blank) begin
      trans = TR_LABEL_BLANK;
    end else if (cfg_i.allow_label_loop && prev_vld_q && (prev_label_q == nb_label)) begin
      trans = TR_LABEL_LOOP;
    end else begin
      trans = TR_LABEL_LABEL;
    end
    is_loop = (trans == TR_LABEL_LOOP) || (trans == TR_BLANK_LOOP);
    act     = is_loop ? (trace_ne_q ? ACT_UPDATE : ACT_NONE) : ACT_PUSH;

    sum = {acc_q[TOTAL_W-1], acc_q}
        + {{(TOTAL_W-SCORE_W+1){nb_score[SCORE_W-1]}}, nb_score};
    if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
      total = sum[TOTAL_W] ? TotMin : TotMax;
    end else begin
      total = sum[TOTAL_W-1:0];
    end
    stop = cfg_i.use_sentence_end && (nb_label == LABEL_BITS'(cfg_i.sentence_end_label));
  end

  always_comb begin
    prev_label_d = prev_label_q;
    prev_vld_d   = prev_vld_q;
    best_score_d = best_score_q;
    best_label_d = best_label_q;
    best_time_d  = best_time_q;
    have_d       = have_q;
    acc_d        = acc_q;
    trace_ne_d   = trace_ne_q;
    if (take_o) begin
      if (mode_i) begin
        prev_label_d = '0;
        prev_vld_d   = 1'b0;
        best_score_d = '0;
        best_label_d = '0;
        best_time_d  = '0;
        have_d       = 1'b0;
        acc_d        = '0;
        trace_ne_d   = 1'b0;
      end else if (last_i) begin
        prev_label_d = nb_label;
        prev_vld_d   = 1'b1;
        best_score_d = '0;
        best_label_d = '0;
        best_time_d  = '0;
        have_d       = 1'b0;
        acc_d        = total;
        trace_ne_d   = trace_ne_q || !is_loop;
      end else begin
        best_score_d = nb_score;
        best_label_d = nb_label;
        best_time_d  = nb_time;
        have_d       = 1'b1;
      end
    end
    res_vld_d = emit ? 1'b1 : (out_ch.ready ? 1'b0 : res_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_label_q <= '0;
      prev_vld_q   <= 1'b0;
      best_score_q <= '0;
      best_label_q <= '0;
      best_time_q  <= '0;
      have_q       <= 1'b0;
      acc_q        <= '0;
      trace_ne_q   <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      prev_label_q <= prev_label_d;
      prev_vld_q   <= prev_vld_d;
      best_score_q <= best_score_d;
      best_label_q <= best_label_d;
      best_time_q  <= best_time_d;
      have_q       <= have_d;
      acc_q        <= acc_d;
      trace_ne_q   <= trace_ne_d;
      res_vld_q    <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_label_q <= nb_label;
      res_trans_q <= trans;
      res_total_q <= total;
      res_act_q   <= act;
      res_time_q  <= nb_time;
      res_stop_q  <= stop;
    end
  end

  assign out_ch.valid        = res_vld_q;
  assign out_ch.best_label   = res_label_q;
  assign out_ch.transition   = res_trans_q;
  assign out_ch.total_score  = res_total_q;
  assign out_ch.trace_action = res_act_q;
  assign out_ch.trace_time   = res_time_q;
  assign out_ch.stop         = res_stop_q;

endmodule

[src/greedy_label_decoder.sv]
// Top level of the greedy label decoder.
// Depends on gld_pkg, gld_in_if, gld_out_if, gld_cfg, gld_in_reg, gld_step.
//
// Usage:
//   in_ch carries one candidate per beat (mode, label, score, timestep,
//   last_label). A run of candidates ends with last_label set; that beat
//   yields one result beat on out_ch. A beat with mode set clears the
//   hypothesis and the partial run and yields no result.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i,
//   one register per cycle. The user must write it only while the block
//   is idle; the block itself does not enforce this.
// Timing: one candidate accepted per cycle unless out_ch stalls.
//   A candidate waits in the input register until the step stage folds it
//   into the state; its result, if any, lands in the result register. The
//   path is one signed compare, one 49-bit add and saturation.
// Reset and stall:
//   Reset clears all configuration registers and the hypothesis. While
//   out_ch stalls with a result pending, one further candidate is held in
//   the input register and in_ch.ready drops.
module greedy_label_decoder import gld_pkg::*; #(
  parameter int LABEL_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gld_in_if.sink                in_ch,
  gld_out_if.source             out_ch
);

  cfg_t                      cfg;
  logic                      take;
  logic                      in_vld;
  logic                      in_mode;
  logic [LABEL_BITS-1:0]     in_label;
  logic signed [SCORE_W-1:0] in_score;
  logic [TIME_W-1:0]         in_time;
  logic                      in_last;

  gld_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  gld_in_reg #(.LABEL_BITS(LABEL_BITS)) u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .take_i     (take),
    .vld_o      (in_vld),
    .mode_o     (in_mode),
    .label_o    (in_label),
    .score_o    (in_score),
    .timestep_o (in_time),
    .last_o     (in_last)
  );

  gld_step #(.LABEL_BITS(LABEL_BITS)) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .vld_i      (in_vld),
    .mode_i     (in_mode),
    .label_i    (in_label),
    .score_i    (in_score),
    .timestep_i (in_time),
    .last_i     (in_last),
    .take_o     (take),
    .out_ch     (out_ch)
  );

  // stop only when enabled
  a_stop_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.stop |-> cfg.use_sentence_end)
    else $error("stop raised while sentence end disabled");

  // update action only on loop transitions
  a_update_on_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && (out_ch.trace_action == ACT_UPDATE) |->
      (out_ch.transition == TR_LABEL_LOOP) || (out_ch.transition == TR_BLANK_LOOP))
    else $error("traceback update without loop transition");

  // a held beat is not dropped
  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld && !take |=> in_vld)
    else $error("input beat lost while stalled");

  // a beat is only taken from a full input register
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> in_vld)
    else $error("step took an empty input register");

endmodule
